FILE: rtl/core/pqh_pkg.sv
package pqh_pkg;

  // Field widths of a request and of a result.
  localparam int CMD_W    = 2;
  localparam int CHAN_W   = 3;
  localparam int WIDTH_W  = 8;
  localparam int STATUS_W = 3;
  localparam int GAP_W    = 10;
  // The hold-off counter holds pos + neg + gap, at most 1533.
  localparam int HOLD_W   = 11;

  // Register port geometry.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register indexes, taken from address bit 2.
  localparam logic REG_ISOLATION = 1'b0;
  localparam logic REG_GAP       = 1'b1;

  localparam logic [GAP_W-1:0] GAP_RESET = 10'd150;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_PUSHED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELIVERED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_HELD      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TICK      = 3'd5;

  // One stored pulse.
  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [WIDTH_W-1:0] pos;
    logic [WIDTH_W-1:0] neg;
  } pulse_t;

  // Configuration seen by the control path.
  typedef struct packed {
    logic             isolation;
    logic [GAP_W-1:0] gap;
  } cfg_t;

endpackage

FILE: rtl/core/pqh_cfg.sv
module pqh_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pqh_pkg::ADDR_W-1:0]   paddr,
  input  logic [pqh_pkg::DATA_W-1:0]   pwdata,
  output logic [pqh_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output pqh_pkg::cfg_t                cfg
);

  logic wr_en;

  // The port never inserts wait states.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes; bits beyond a register's width are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.isolation <= 1'b0;
      cfg.gap       <= pqh_pkg::GAP_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        pqh_pkg::REG_ISOLATION: cfg.isolation <= pwdata[0];
        pqh_pkg::REG_GAP:       cfg.gap       <= pwdata[pqh_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (paddr[2])
      pqh_pkg::REG_ISOLATION: prdata = {{(pqh_pkg::DATA_W-1){1'b0}}, cfg.isolation};
      pqh_pkg::REG_GAP:
        prdata = {{(pqh_pkg::DATA_W-pqh_pkg::GAP_W){1'b0}}, cfg.gap};
      default: prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/pqh_store.sv
module pqh_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  pqh_pkg::pulse_t   wr_data,
  input  logic [AW-1:0]     rd_addr,
  output pqh_pkg::pulse_t   rd_data
);

  pqh_pkg::pulse_t mem [DEPTH];
  pqh_pkg::pulse_t rd_q;
  pqh_pkg::pulse_t byp_data;
  logic            byp;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // A write to the entry being read this cycle is forwarded, so the head
  // is correct right after a push into an empty queue.
  always_ff @(posedge clk) begin
    byp      <= wr_en && (wr_addr == rd_addr);
    byp_data <= wr_data;
  end

  assign rd_data = byp ? byp_data : rd_q;

endmodule

FILE: rtl/core/pulse_queue_with_holdoff.sv
// Channel    | Direction | Handshake               | Payload
// request    | in        | req_valid / req_stall   | cmd, pulse_channel, pos_width, neg_width
// result     | out       | res_valid / res_stall   | status, out_channel, out_pos_width,
//            |           |                         | out_neg_width
// registers  | in/out    | APB psel/penable/pready | paddr, pwdata, prdata
//
// A request is taken every cycle unless a stalled result holds the input register; its
// result is loaded into the result register from the input register. The queue head is
// read ahead from the store's registered read port, addressed by rd_ptr_next.
// Synchronous reset clears pointers, fill count, hold-off and registers; the store
// itself is not cleared. A stalled result holds the input register, which then
// stalls the request side. A command code of 3 is consumed with no result.
module pulse_queue_with_holdoff #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // Request channel.
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [pqh_pkg::CMD_W-1:0]       cmd,
  input  logic [pqh_pkg::CHAN_W-1:0]      pulse_channel,
  input  logic [pqh_pkg::WIDTH_W-1:0]     pos_width,
  input  logic [pqh_pkg::WIDTH_W-1:0]     neg_width,
  // Result channel.
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic [pqh_pkg::STATUS_W-1:0]    status,
  output logic [pqh_pkg::CHAN_W-1:0]      out_channel,
  output logic [pqh_pkg::WIDTH_W-1:0]     out_pos_width,
  output logic [pqh_pkg::WIDTH_W-1:0]     out_neg_width,
  // Register port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pqh_pkg::ADDR_W-1:0]      paddr,
  input  logic [pqh_pkg::DATA_W-1:0]      pwdata,
  output logic [pqh_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  pqh_pkg::cfg_t   cfg;

  // Input register.
  logic                          in_full;
  logic [pqh_pkg::CMD_W-1:0]     in_cmd;
  pqh_pkg::pulse_t               in_pulse;

  // Queue and hold-off state.
  logic [PTR_W-1:0]              rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0]              wr_ptr, wr_ptr_next;
  logic [CNT_W-1:0]              count, count_next;
  logic [pqh_pkg::HOLD_W-1:0]    hold, hold_next;

  pqh_pkg::pulse_t               head;
  logic                          take;
  logic                          push_ok;
  logic                          produce;
  logic                          deliver;
  logic [pqh_pkg::STATUS_W-1:0]  status_next;

  pqh_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pqh_store #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (PTR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (push_ok),
    .wr_addr (wr_ptr),
    .wr_data (in_pulse),
    .rd_addr (rd_ptr_next),
    .rd_data (head)
  );

  // The input register moves on whenever the result register is free.
  assign take      = in_full && (!res_valid || !res_stall);
  assign req_stall = in_full && !(!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (req_valid && !req_stall) begin
      in_full <= 1'b1;
    end else if (take) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      in_cmd        <= cmd;
      in_pulse.chan <= pulse_channel;
      in_pulse.pos  <= pos_width;
      in_pulse.neg  <= neg_width;
    end
  end

  // Command decode and state update for the request in the input register.
  always_comb begin
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    count_next  = count;
    hold_next   = hold;
    push_ok     = 1'b0;
    deliver     = 1'b0;
    produce     = 1'b0;
    status_next = pqh_pkg::ST_TICK;
    if (take) begin
      case (in_cmd)
        pqh_pkg::CMD_PUSH: begin
          produce = 1'b1;
          if (count == FULL_CNT) begin
            status_next = pqh_pkg::ST_FULL;
          end else begin
            push_ok     = 1'b1;
            wr_ptr_next = (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
            count_next  = count + 1'b1;
            status_next = pqh_pkg::ST_PUSHED;
          end
        end
        pqh_pkg::CMD_POP: begin
          produce = 1'b1;
          if (count == '0) begin
            status_next = pqh_pkg::ST_EMPTY;
          end else if (cfg.isolation && (hold != '0)) begin
            status_next = pqh_pkg::ST_HELD;
          end else begin
            deliver     = 1'b1;
            rd_ptr_next = (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
            count_next  = count - 1'b1;
            hold_next   = pqh_pkg::HOLD_W'(head.pos) + pqh_pkg::HOLD_W'(head.neg)
                        + pqh_pkg::HOLD_W'(cfg.gap);
            status_next = pqh_pkg::ST_DELIVERED;
          end
        end
        pqh_pkg::CMD_TICK: begin
          produce     = 1'b1;
          status_next = pqh_pkg::ST_TICK;
          if (hold != '0) begin
            hold_next = hold - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
      hold   <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      hold   <= hold_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take && produce) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && produce) begin
      status        <= status_next;
      out_channel   <= deliver ? head.chan : '0;
      out_pos_width <= deliver ? head.pos : '0;
      out_neg_width <= deliver ? head.neg : '0;
    end
  end

endmodule
